@@ hdl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted (active low).
`define CHK_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("check failed");

// Same, with a message of the caller's choice.
`define CHK_ASSERT_MSG(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);

`endif

@@ hdl/swms_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package swms_pkg;

  // Field and state widths
  localparam int unsigned SampleW   = 24;
  localparam int unsigned StampW    = 63;
  localparam int unsigned LenW      = 9;
  localparam int unsigned WindowMax = 256;
  localparam int unsigned PtrW      = $clog2(WindowMax);
  localparam int unsigned SumW      = 32;
  localparam int unsigned SqW       = 55;
  localparam int unsigned SqLoW     = 28;
  localparam int unsigned MulW      = 32;

  // Shared divider and root unit
  localparam int unsigned DivW    = 64;
  localparam int unsigned DivsW   = 16;
  localparam int unsigned DivCntW = 5;
  localparam int unsigned RootW   = 32;

  // Window length register
  localparam logic [LenW-1:0] LenReset = LenW'(20);
  localparam logic [LenW-1:0] LenMin   = LenW'(2);
  localparam logic [LenW-1:0] LenMax   = LenW'(WindowMax);

  typedef struct packed {
    logic              start;
    logic              wide;     // 64-bit dividend, else the low half only
    logic [DivW-1:0]   dividend;
    logic [DivsW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DivW-1:0]   quo;
    logic [DivsW-1:0]  rem;
  } div_rsp_t;

  typedef struct packed {
    logic              start;
    logic [DivW-1:0]   radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic              done;
    logic [RootW-1:0]  root;
  } sqrt_rsp_t;

  // Sequencer states, one-hot
  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_SQY  = 13'b0000000000010,
    S_SQX  = 13'b0000000000100,
    S_ACC  = 13'b0000000001000,
    S_MAG  = 13'b0000000010000,
    S_NLO  = 13'b0000000100000,
    S_NHI  = 13'b0000001000000,
    S_NUM  = 13'b0000010000000,
    S_SUB  = 13'b0000100000000,
    S_MDIV = 13'b0001000000000,
    S_VDIV = 13'b0010000000000,
    S_ROOT = 13'b0100000000000,
    S_OUT  = 13'b1000000000000
  } state_e;

endpackage

`default_nettype wire

@@ hdl/swms_dline.sv @@
`timescale 1ns / 1ps
`default_nettype none

module swms_dline (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [swms_pkg::PtrW-1:0]     waddr_i,
  input  logic [swms_pkg::SampleW-1:0]  wdata_i,
  input  logic                          re_i,
  input  logic [swms_pkg::PtrW-1:0]     raddr_i,
  output logic [swms_pkg::SampleW-1:0]  rdata_o
);
  import swms_pkg::*;

  logic [SampleW-1:0] mem [WindowMax];
  logic [SampleW-1:0] rdata_q;

  // Sample store, one write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hdl/swms_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, two quotient bits per cycle.
module swms_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  swms_pkg::div_req_t req_i,
  output swms_pkg::div_rsp_t rsp_o
);
  import swms_pkg::*;

  localparam int unsigned HalfW = DivW / 2;
  localparam logic [DivCntW-1:0] CntWide   = DivCntW'(DivW / 2 - 1);
  localparam logic [DivCntW-1:0] CntNarrow = DivCntW'(DivW / 4 - 1);

  logic               busy_q, done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DivW-1:0]    dvd_q, quo_q;
  logic [DivsW-1:0]   rem_q, dvs_q;

  logic [DivsW:0]     t1, t2, dvs_ext, r1, r2;
  logic               ge1, ge2;

  // Two chained compare-subtract steps
  always_comb begin
    dvs_ext = {1'b0, dvs_q};
    t1  = {rem_q, dvd_q[DivW-1]};
    ge1 = (t1 >= dvs_ext);
    r1  = ge1 ? (t1 - dvs_ext) : t1;
    t2  = {r1[DivsW-1:0], dvd_q[DivW-2]};
    ge2 = (t2 >= dvs_ext);
    r2  = ge2 ? (t2 - dvs_ext) : t2;
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.wide ? CntWide : CntNarrow;
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      dvd_q <= req_i.wide ? req_i.dividend : {req_i.dividend[HalfW-1:0], {HalfW{1'b0}}};
      quo_q <= '0;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DivW-3:0], 2'b00};
      quo_q <= {quo_q[DivW-3:0], ge1, ge2};
      rem_q <= r2[DivsW-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

@@ hdl/swms_sqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Digit-by-digit integer square root, one root bit per cycle.
module swms_sqrt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  swms_pkg::sqrt_req_t req_i,
  output swms_pkg::sqrt_rsp_t rsp_o
);
  import swms_pkg::*;

  localparam logic [DivCntW-1:0] CntLoad = DivCntW'(RootW - 1);

  logic               busy_q, done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DivW-1:0]    rad_q;
  logic [RootW-1:0]   root_q;
  logic [RootW:0]     rem_q;

  logic [RootW+2:0]   part, trial, diff;
  logic               ge;

  // Trial subtraction of 4*root + 1
  always_comb begin
    part  = {rem_q, rad_q[DivW-1:DivW-2]};
    trial = {1'b0, root_q, 2'b01};
    ge    = (part >= trial);
    diff  = ge ? (part - trial) : part;
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CntLoad;
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      rad_q  <= req_i.radicand;
      root_q <= '0;
      rem_q  <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[DivW-3:0], 2'b00};
      root_q <= {root_q[RootW-2:0], ge};
      rem_q  <= diff[RootW:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q;

endmodule

`default_nettype wire

@@ hdl/sliding_window_mean_stddev.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Sliding-window mean and sample standard deviation.
// Input channel (in_valid_i/in_ready_o): sample, timestamp and a series-end
// flag. Output channel (out_valid_o/out_ready_i): timestamp, floored window
// mean and floored sample standard deviation, one result per sample once the
// window holds window_len samples. Config channel (cfg_valid_i/cfg_ready_o)
// writes window_len (clamped to 2..256) and clears the window.
// One sample is processed at a time; the next is taken only when the
// sequencer is back in idle. The time to a result is set by the shared
// divider (16 two-bit steps for the mean, 32 for the variance) and the
// 32-step square root unit.
// The sample history lives in a 256-entry memory; the evicted sample is read
// in the transfer cycle and the new one is written in the following cycle.
// Reset sets window_len to 20 and empties the window; no clearing pass.
// A finished result waits in the output register; the next sample is taken
// meanwhile, and its own result waits until the receiver takes the first.
// A series-end flag empties the window after its sample is processed.
module sliding_window_mean_stddev (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [swms_pkg::LenW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [swms_pkg::SampleW-1:0]  sample_i,
  input  logic [swms_pkg::StampW-1:0]   stamp_i,
  input  logic                          series_end_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [swms_pkg::StampW-1:0]   out_stamp_o,
  output logic [swms_pkg::SampleW-1:0]  window_mean_o,
  output logic [swms_pkg::SampleW-1:0]  window_stddev_o
);
  import swms_pkg::*;

  localparam int unsigned HalfW = DivW / 2;

  // Control state
  state_e            state_q, state_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [PtrW-1:0]   wp_q, wp_d;
  logic [LenW-1:0]   fill_q, fill_d;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [SqW-1:0]    sumsq_q, sumsq_d;
  logic              out_valid_q, out_valid_d;

  // Item payload and work registers
  logic [SampleW-1:0] x_q;
  logic [StampW-1:0]  stamp_q;
  logic               end_q, evict_q;
  logic [2*MulW-1:0]  prod_q;
  logic [DivW-1:0]    acc_q, b_q;
  logic [DivsW-1:0]   nn_q;
  logic [SampleW-1:0] mean_q;
  logic               neg_q;
  logic [StampW-1:0]  out_stamp_q;
  logic [SampleW-1:0] out_mean_q, out_sd_q;

  // Memory and shared units
  logic               mem_re, mem_we;
  logic [PtrW-1:0]    mem_raddr;
  logic [SampleW-1:0] y_w;
  div_req_t           div_req;
  div_rsp_t           div_rsp;
  sqrt_req_t          sqrt_req;
  sqrt_rsp_t          sqrt_rsp;

  // Combinational helpers
  logic [LenW-1:0]    n_w;
  logic [2*LenW-1:0]  nn_full;
  logic [SampleW-1:0] ymag, xmag;
  logic [SumW-1:0]    x_ext, y_ext, mag;
  logic [MulW-1:0]    mul_a, mul_b;
  logic [2*MulW-1:0]  prod_d;
  logic               in_xfer, cfg_xfer, out_load;
  logic [SampleW-1:0] dq;

  // Effective window length
  always_comb begin
    if (len_q < LenMin) begin
      n_w = LenMin;
    end else if (len_q > LenMax) begin
      n_w = LenMax;
    end else begin
      n_w = len_q;
    end
  end

  assign nn_full = n_w * (n_w - 1'b1);

  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_ready_o  = (state_q == S_IDLE) && !cfg_valid_i;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  // Magnitudes and sign extensions
  assign ymag  = y_w[SampleW-1] ? (~y_w + 1'b1) : y_w;
  assign xmag  = x_q[SampleW-1] ? (~x_q + 1'b1) : x_q;
  assign x_ext = {{(SumW-SampleW){x_q[SampleW-1]}}, x_q};
  assign y_ext = {{(SumW-SampleW){y_w[SampleW-1]}}, y_w};
  assign mag   = sum_q[SumW-1] ? (~sum_q + 1'b1) : sum_q;

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_SQY: begin
        mul_a = MulW'(ymag);
        mul_b = MulW'(ymag);
      end
      S_SQX: begin
        mul_a = MulW'(xmag);
        mul_b = MulW'(xmag);
      end
      S_MAG: begin
        mul_a = mag;
        mul_b = mag;
      end
      S_NLO: begin
        mul_a = MulW'(n_w);
        mul_b = MulW'(sumsq_q[SqLoW-1:0]);
      end
      S_NHI: begin
        mul_a = MulW'(n_w);
        mul_b = MulW'(sumsq_q[SqW-1:SqLoW]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // Memory port control
  assign mem_re    = in_xfer;
  assign mem_raddr = wp_q - n_w[PtrW-1:0];
  assign mem_we    = (state_q == S_SQY);

  swms_dline u_dline (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wp_q),
    .wdata_i (x_q),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (y_w)
  );

  // Divider and root requests
  always_comb begin
    div_req          = '0;
    sqrt_req         = '0;
    sqrt_req.radicand = div_rsp.quo;
    if (state_q == S_SUB) begin
      div_req.start    = 1'b1;
      div_req.wide     = 1'b0;
      div_req.dividend = {{HalfW{1'b0}}, mag};
      div_req.divisor  = DivsW'(n_w);
    end else if (state_q == S_MDIV) begin
      div_req.start    = div_rsp.done;
      div_req.wide     = 1'b1;
      div_req.dividend = acc_q;
      div_req.divisor  = nn_q;
    end
    if (state_q == S_VDIV) begin
      sqrt_req.start = div_rsp.done;
    end
  end

  swms_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  swms_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sqrt_req),
    .rsp_o  (sqrt_rsp)
  );

  // Floored mean from quotient magnitude and remainder
  always_comb begin
    if (!neg_q) begin
      dq = div_rsp.quo[SampleW-1:0];
    end else if (div_rsp.rem != '0) begin
      dq = ~div_rsp.quo[SampleW-1:0];
    end else begin
      dq = ~div_rsp.quo[SampleW-1:0] + 1'b1;
    end
  end

  // Sequencer and window state
  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    wp_d        = wp_q;
    fill_d      = fill_q;
    sum_d       = sum_q;
    sumsq_d     = sumsq_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (cfg_xfer) begin
          len_d   = cfg_data_i;
          wp_d    = '0;
          fill_d  = '0;
          sum_d   = '0;
          sumsq_d = '0;
        end else if (in_xfer) begin
          state_d = S_SQY;
        end
      end
      S_SQY: state_d = S_SQX;
      S_SQX: begin
        sum_d   = sum_q - (evict_q ? y_ext : '0) + x_ext;
        sumsq_d = sumsq_q - (evict_q ? prod_q[SqW-1:0] : '0);
        wp_d    = wp_q + 1'b1;
        if (fill_q < n_w) begin
          fill_d = fill_q + 1'b1;
        end
        state_d = S_ACC;
      end
      S_ACC: begin
        sumsq_d = sumsq_q + prod_q[SqW-1:0];
        if (fill_q >= n_w) begin
          state_d = S_MAG;
        end else begin
          state_d = S_IDLE;
          if (end_q) begin
            wp_d    = '0;
            fill_d  = '0;
            sum_d   = '0;
            sumsq_d = '0;
          end
        end
      end
      S_MAG:  state_d = S_NLO;
      S_NLO:  state_d = S_NHI;
      S_NHI:  state_d = S_NUM;
      S_NUM:  state_d = S_SUB;
      S_SUB:  state_d = S_MDIV;
      S_MDIV: begin
        if (div_rsp.done) begin
          state_d = S_VDIV;
        end
      end
      S_VDIV: begin
        if (div_rsp.done) begin
          state_d = S_ROOT;
        end
      end
      S_ROOT: begin
        if (sqrt_rsp.done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          if (end_q) begin
            wp_d    = '0;
            fill_d  = '0;
            sum_d   = '0;
            sumsq_d = '0;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= LenReset;
      wp_q        <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      sumsq_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      wp_q        <= wp_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      sumsq_q     <= sumsq_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Work registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (in_xfer) begin
      x_q     <= sample_i;
      stamp_q <= stamp_i;
      end_q   <= series_end_i;
      evict_q <= (fill_q >= n_w);
    end
    if (state_q == S_MAG) begin
      neg_q <= sum_q[SumW-1];
    end
    if (state_q == S_NLO) begin
      b_q  <= prod_q;
      nn_q <= nn_full[DivsW-1:0];
    end
    if (state_q == S_NHI) begin
      acc_q <= prod_q;
    end
    if (state_q == S_NUM) begin
      acc_q <= acc_q + (prod_q << SqLoW);
    end
    if (state_q == S_SUB) begin
      acc_q <= (acc_q >= b_q) ? (acc_q - b_q) : '0;
    end
    if ((state_q == S_MDIV) && div_rsp.done) begin
      mean_q <= dq;
    end
    if (out_load) begin
      out_stamp_q <= stamp_q;
      out_mean_q  <= mean_q;
      out_sd_q    <= sqrt_rsp.root[SampleW-1:0];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_stamp_o     = out_stamp_q;
  assign window_mean_o   = out_mean_q;
  assign window_stddev_o = out_sd_q;

endmodule

`default_nettype wire

@@ hdl/swms_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module swms_chk (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_o,
  input  logic [swms_pkg::LenW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_o,
  input  logic [swms_pkg::SampleW-1:0]  sample_i,
  input  logic [swms_pkg::StampW-1:0]   stamp_i,
  input  logic                          series_end_i,
  input  logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  logic [swms_pkg::StampW-1:0]   out_stamp_o,
  input  logic [swms_pkg::SampleW-1:0]  window_mean_o,
  input  logic [swms_pkg::SampleW-1:0]  window_stddev_o
);

  // One sample in flight: no transfer right after a transfer
  `CHK_ASSERT_MSG(a_one_item, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o, "input taken while busy")

  // Samples are only taken while a config write could be taken too
  `CHK_ASSERT(a_ready_order, clk_i, rst_ni, in_ready_o |-> cfg_ready_o)

  // A new result never shows in the cycle right after a sample transfer
  `CHK_ASSERT_MSG(a_no_instant, clk_i, rst_ni, $rose(out_valid_o) |-> !$past(in_valid_i && in_ready_o), "result too early")

  // A stalled result holds
  `CHK_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_stamp_o) && $stable(window_mean_o) && $stable(window_stddev_o)))

endmodule

bind sliding_window_mean_stddev swms_chk u_swms_chk (.*);

`default_nettype wire
